[hw/rtl/mbre_pkg.sv]
package mbre_pkg;

  // Pixels per framebuffer element, packed MSB-first.
  localparam int ELEM_BITS = 8;

  typedef enum logic [2:0] {
    CMD_POINT = 3'd0,
    CMD_HLINE = 3'd1,
    CMD_VLINE = 3'd2,
    CMD_RECT  = 3'd3,
    CMD_FILL  = 3'd4,
    CMD_ALL   = 3'd5,
    CMD_SPR   = 3'd6,
    CMD_READ  = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    OP_SET = 2'd0,
    OP_CLR = 2'd1,
    OP_INV = 2'd2,
    OP_NOP = 2'd3
  } op_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [1:0] op;
    logic [6:0] x;
    logic [5:0] y;
    logic [6:0] x_last;
    logic [5:0] y_last;
    logic [7:0] w;
    logic [6:0] h;
    logic [7:0] pattern;
    logic       invert;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       status;
  } out_item_t;

  // Normalized job for the back end: a column span times a row span.
  // Coordinates are 11 bits so that spans past the buffer edge are exact.
  typedef struct packed {
    logic        read;
    logic        all;
    logic        spr;
    logic        empty;
    logic [1:0]  op;
    logic [10:0] x0;
    logic [10:0] x1;
    logic [10:0] y0;
    logic [10:0] y1;
    logic [7:0]  pat;
    logic        last;
  } job_t;

endpackage

[hw/rtl/mbre_front.sv]
module mbre_front import mbre_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output logic     job_valid_o,
  input  logic     job_stall_i,
  output job_t     job_o
);
  // Splits one item into jobs; a non-empty outline gives four line jobs in order.
  logic [1:0] part_q, part_d;
  job_t j;
  logic [10:0] xr, yb;
  logic nparts_last;

  always_comb begin
    j = '0;
    xr = 11'(in_item_i.x) + 11'(in_item_i.w) - 11'd1;
    yb = 11'(in_item_i.y) + 11'(in_item_i.h) - 11'd1;
    j.op = in_item_i.op;
    j.x0 = 11'(in_item_i.x);
    j.x1 = 11'(in_item_i.x);
    j.y0 = 11'(in_item_i.y);
    j.y1 = 11'(in_item_i.y);
    j.pat = in_item_i.pattern ^ {8{in_item_i.invert}};
    nparts_last = 1'b1;
    unique case (cmd_e'(in_item_i.cmd))
      CMD_POINT: ;
      CMD_HLINE: begin
        j.x1 = 11'(in_item_i.x_last);
        j.empty = in_item_i.x_last < in_item_i.x;
      end
      CMD_VLINE: begin
        j.y1 = 11'(in_item_i.y_last);
        j.empty = in_item_i.y_last < in_item_i.y;
      end
      CMD_RECT: begin
        j.empty = (in_item_i.w == 8'd0) || (in_item_i.h == 7'd0);
        nparts_last = j.empty || (part_q == 2'd3);
        case (part_q)
          2'd0: j.x1 = xr;
          2'd1: begin j.x1 = xr; j.y0 = yb; j.y1 = yb; end
          2'd2: j.y1 = yb;
          default: begin j.x0 = xr; j.x1 = xr; j.y1 = yb; end
        endcase
      end
      CMD_FILL: begin
        j.empty = (in_item_i.w == 8'd0) || (in_item_i.h == 7'd0);
        j.x1 = xr;
        j.y1 = yb;
      end
      CMD_ALL: j.all = 1'b1;
      CMD_SPR: begin
        j.spr = 1'b1;
        j.empty = in_item_i.w == 8'd0;
        j.x1 = 11'(in_item_i.x) + ((in_item_i.w > 8'd8) ? 11'd7 : 11'(in_item_i.w) - 11'd1);
      end
      CMD_READ: j.read = 1'b1;
      default: ;
    endcase
    j.last = nparts_last;
    part_d = part_q;
    if (in_valid_i && !job_stall_i) part_d = nparts_last ? 2'd0 : part_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) part_q <= '0;
    else part_q <= part_d;
  end

  assign job_o = j;
  assign job_valid_o = in_valid_i;
  assign in_stall_o = job_stall_i || !nparts_last;
endmodule

[hw/rtl/mbre_queue.sv]
module mbre_queue import mbre_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_stall_o,
  input  job_t wr_job_i,
  output logic rd_valid_o,
  input  logic rd_take_i,
  output job_t rd_job_o
);
  job_t mem_q [2];
  logic [1:0] cnt_q;
  logic wp_q, rp_q;
  logic wr, rd;

  assign wr_stall_o = cnt_q == 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_job_o = mem_q[rp_q];
  assign wr = wr_valid_i && !wr_stall_o;
  assign rd = rd_take_i && rd_valid_o;

  always_ff @(posedge clk_i) if (wr) mem_q[wp_q] <= wr_job_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; wp_q <= 1'b0; rp_q <= 1'b0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end
endmodule

[hw/rtl/mbre_back.sv]
module mbre_back import mbre_pkg::*; #(
  parameter int FB_WIDTH  = 128,
  parameter int FB_HEIGHT = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  output logic      job_take_o,
  input  job_t      job_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);
  localparam int RowElems = (FB_WIDTH + ELEM_BITS - 1) / ELEM_BITS;
  localparam int Depth = RowElems * FB_HEIGHT;
  localparam int AW = $clog2(Depth);
  localparam int CW = $clog2(RowElems + 1);
  localparam int SW = $clog2(ELEM_BITS);
  localparam int RW = $clog2(FB_HEIGHT + 1);
  localparam logic [10:0] FbW = 11'(FB_WIDTH);
  localparam logic [10:0] FbH = 11'(FB_HEIGHT);
  localparam logic [10:0] Eb = 11'(ELEM_BITS);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_WR, S_RES} state_e;
  typedef logic [ELEM_BITS-1:0] elem_t;

  elem_t mem [Depth];
  elem_t rdat_q;
  state_e st_q;
  job_t job_q;
  logic [AW-1:0] addr_q;
  logic [AW:0] clr_q;
  logic [CW-1:0] col_q, cend_q, c0_q;
  logic [RW-1:0] row_q, rend_q;
  logic oob_q;
  out_item_t res_q;
  logic ov_q;

  // Column span clipped to the buffer.
  logic [10:0] cx0, cx1, cy1;
  job_t jclip;
  always_comb begin
    cx1 = (job_i.x1 >= FbW) ? FbW - 11'd1 : job_i.x1;
    cy1 = (job_i.y1 >= FbH) ? FbH - 11'd1 : job_i.y1;
    cx0 = job_i.x0;
    jclip = job_i;
    jclip.x1 = cx1;
  end

  // Mask of pixels of element col_q covered by job_q span.
  elem_t emask, newv, spv;
  logic [10:0] ebase, lo, hi;
  logic [2*ELEM_BITS-1:0] spw;
  always_comb begin
    ebase = 11'(col_q) * Eb;
    lo = (job_q.x0 > ebase) ? job_q.x0 - ebase : 11'd0;
    hi = (job_q.x1 < ebase + Eb - 11'd1) ? job_q.x1 - ebase : Eb - 11'd1;
    emask = ({ELEM_BITS{1'b1}} >> lo[SW-1:0]) & ~({ELEM_BITS{1'b1}} >> (hi[SW-1:0] + 1'b1));
    if (hi == Eb - 11'd1) emask = {ELEM_BITS{1'b1}} >> lo[SW-1:0];
    spw = {8'(job_q.pat), {(2*ELEM_BITS-8){1'b0}}} >> job_q.x0[SW-1:0];
    if (job_q.x0[10:0] / Eb == 11'(col_q)) spv = spw[2*ELEM_BITS-1 -: ELEM_BITS];
    else spv = spw[ELEM_BITS-1:0];
    if (job_q.all) emask = {ELEM_BITS{1'b1}};
    newv = rdat_q;
    if (job_q.spr) newv = (rdat_q & ~emask) | (spv & emask);
    else case (op_e'(job_q.op))
      OP_SET: newv = rdat_q | emask;
      OP_CLR: newv = rdat_q & ~emask;
      OP_INV: newv = rdat_q ^ emask;
      default: newv = rdat_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rdat_q <= mem[addr_q];
    if (st_q == S_CLR) mem[clr_q[AW-1:0]] <= '0;
    else if (st_q == S_WR) mem[addr_q] <= newv;
  end

  // A pending result does not hold off the next job; S_RES waits for it.
  assign job_take_o = (st_q == S_IDLE) && job_valid_i;
  assign out_valid_o = ov_q;
  assign out_item_o = res_q;

  logic [AW-1:0] nxt_addr;
  logic end_col, end_row;
  always_comb begin
    end_col = col_q == cend_q;
    end_row = row_q == rend_q;
    nxt_addr = end_col ? AW'((32'(row_q) + 1) * RowElems + 32'(c0_q))
                       : addr_q + AW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; clr_q <= '0; ov_q <= 1'b0; addr_q <= '0;
      col_q <= '0; cend_q <= '0; row_q <= '0; rend_q <= '0; c0_q <= '0;
      oob_q <= 1'b0; res_q <= '0; job_q <= '0;
    end else begin
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      unique case (st_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (AW+1)'(Depth - 1)) st_q <= S_IDLE;
        end
        S_IDLE: if (job_take_o) begin
          job_q <= jclip;
          // skipped pixels: any part of the span beyond the buffer
          if (!job_i.empty && !job_i.all && !job_i.read &&
              (job_i.x1 >= FbW || job_i.y1 >= FbH || job_i.x0 >= FbW ||
               job_i.y0 >= FbH)) oob_q <= 1'b1;
          if (job_i.read) begin
            addr_q <= AW'(32'(job_i.y0) * RowElems + 32'(job_i.x0 / Eb));
            st_q <= (job_i.x0 >= FbW || job_i.y0 >= FbH) ? S_RES : S_RD;
            if (job_i.x0 >= FbW || job_i.y0 >= FbH) oob_q <= 1'b1;
          end else if (job_i.all) begin
            addr_q <= '0; col_q <= '0; row_q <= '0; c0_q <= '0;
            cend_q <= CW'(RowElems - 1); rend_q <= RW'(FB_HEIGHT - 1);
            st_q <= S_RD;
          end else if (job_i.empty || cx0 >= FbW || job_i.y0 >= FbH) begin
            st_q <= job_i.last ? S_RES : S_IDLE;
          end else begin
            addr_q <= AW'(32'(job_i.y0) * RowElems + 32'(cx0 / Eb));
            col_q <= CW'(cx0 / Eb); c0_q <= CW'(cx0 / Eb);
            cend_q <= CW'(cx1 / Eb);
            row_q <= RW'(job_i.y0); rend_q <= RW'(cy1);
            st_q <= S_RD;
          end
        end
        S_RD: st_q <= job_q.read ? S_RES : S_WR;
        S_WR: begin
          if (end_col && end_row) st_q <= job_q.last ? S_RES : S_IDLE;
          else begin
            st_q <= S_RD;
            addr_q <= nxt_addr;
            if (end_col) begin col_q <= c0_q; row_q <= row_q + 1'b1; end
            else col_q <= col_q + 1'b1;
          end
        end
        S_RES: if (!ov_q) begin
          ov_q <= 1'b1;
          res_q.status <= oob_q;
          res_q.read_data <= (job_q.read && !oob_q) ? 8'(rdat_q) : 8'd0;
          oob_q <= 1'b0;
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule

[hw/rtl/mono_bitmap_raster_engine.sv]
// The back end reads then writes each framebuffer element that a job touches; a read
// only reads its element, and an empty command touches none before its result is offered.
// An outline queues its four line jobs back to back and reports after the last one.
// One job walks at a time through the back end's element read-modify-write loop.
// Reset: asynchronous, active low; a clearing pass zeroes the framebuffer.
module mono_bitmap_raster_engine import mbre_pkg::*; #(
  parameter int FB_WIDTH  = 128,
  parameter int FB_HEIGHT = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);
  logic fj_valid, fj_stall, qv, qtake;
  job_t fj, qj;

  // Front: split commands into span jobs.
  mbre_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .job_valid_o(fj_valid), .job_stall_i(fj_stall), .job_o(fj)
  );

  mbre_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(fj_valid), .wr_stall_o(fj_stall),
    .wr_job_i(fj), .rd_valid_o(qv), .rd_take_i(qtake), .rd_job_o(qj)
  );

  // Back: element read-modify-write walker.
  mbre_back #(
    .FB_WIDTH(FB_WIDTH), .FB_HEIGHT(FB_HEIGHT)
  ) u_back (
    .clk_i, .rst_ni, .job_valid_i(qv), .job_take_o(qtake), .job_i(qj),
    .out_valid_o, .out_stall_i, .out_item_o
  );
endmodule

[verif/mono_bitmap_raster_engine_tb.sv]
module mono_bitmap_raster_engine_tb;
  import mbre_pkg::*;

  localparam int FB_W      = 128;
  localparam int FB_H      = 64;
  localparam int ROW_ELEMS = FB_W / 8;
  localparam int DEPTH     = ROW_ELEMS * FB_H;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  mono_bitmap_raster_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // Shadow copy of the framebuffer, one byte per element, MSB = leftmost pixel.
  logic [7:0] shadow_fb [DEPTH];
  out_item_t  expected_q [$];
  int         mismatches;
  int         results_seen;
  int         cmd_count [8];
  bit         calm;  // no idling on either side once set

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #200_000_000;
    $display("status: fail");
    $finish;
  end

  // Apply op to one pixel; returns 1 when the pixel is off the buffer.
  function automatic bit touch_pixel(int px, int py, op_e op);
    int idx;
    logic [7:0] m;
    if (px >= FB_W || py >= FB_H) return 1'b1;
    idx = py * ROW_ELEMS + px / 8;
    m   = 8'h80 >> (px % 8);
    case (op)
      OP_SET:  shadow_fb[idx] = shadow_fb[idx] | m;
      OP_CLR:  shadow_fb[idx] = shadow_fb[idx] & ~m;
      OP_INV:  shadow_fb[idx] = shadow_fb[idx] ^ m;
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic bit draw_row(int x0, int x1, int py, op_e op);
    bit off;
    off = 1'b0;
    for (int px = x0; px <= x1; px++) off |= touch_pixel(px, py, op);
    return off;
  endfunction

  function automatic bit draw_col(int y0, int y1, int px, op_e op);
    bit off;
    off = 1'b0;
    for (int py = y0; py <= y1; py++) off |= touch_pixel(px, py, op);
    return off;
  endfunction

  // Updates the shadow framebuffer and returns the result the block owes.
  function automatic out_item_t raster_outcome(in_item_t it);
    out_item_t r;
    op_e op;
    int x, y, w, h, xr, yb, wid;
    bit v;
    r  = '0;
    op = op_e'(it.op);
    x  = it.x;
    y  = it.y;
    w  = it.w;
    h  = it.h;
    case (cmd_e'(it.cmd))
      CMD_POINT: r.status = touch_pixel(x, y, op);
      CMD_HLINE: if (it.x_last >= it.x) r.status = draw_row(x, it.x_last, y, op);
      CMD_VLINE: if (it.y_last >= it.y) r.status = draw_col(y, it.y_last, x, op);
      CMD_RECT: begin
        if (w != 0 && h != 0) begin
          // Four lines in sequence: corners see the op twice.
          xr = x + w - 1;
          yb = y + h - 1;
          r.status |= draw_row(x, xr, y, op);
          r.status |= draw_row(x, xr, yb, op);
          r.status |= draw_col(y, yb, x, op);
          r.status |= draw_col(y, yb, xr, op);
        end
      end
      CMD_FILL: begin
        if (w != 0 && h != 0)
          for (int py = y; py < y + h; py++) r.status |= draw_row(x, x + w - 1, py, op);
      end
      CMD_ALL: begin
        for (int i = 0; i < DEPTH; i++)
          case (op)
            OP_SET:  shadow_fb[i] = 8'hFF;
            OP_CLR:  shadow_fb[i] = 8'h00;
            OP_INV:  shadow_fb[i] = ~shadow_fb[i];
            default: ;
          endcase
      end
      CMD_SPR: begin
        // op is ignored; width saturates at 8
        wid = (w > 8) ? 8 : w;
        for (int i = 0; i < wid; i++) begin
          v = it.pattern[7 - i] ^ it.invert;
          r.status |= touch_pixel(x + i, y, v ? OP_SET : OP_CLR);
        end
      end
      default: begin
        if (x >= FB_W || y >= FB_H) r.status = 1'b1;
        else r.read_data = shadow_fb[y * ROW_ELEMS + x / 8];
      end
    endcase
    return r;
  endfunction

  // Send one item; valid stays high between back-to-back items.
  task automatic send_item(in_item_t it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    // stall settles by the falling edge and holds to the next rising edge
    forever begin
      @(negedge clk_i);
      if (!in_stall_o) break;
    end
    @(posedge clk_i);
    expected_q.push_back(raster_outcome(it));
    cmd_count[it.cmd]++;
  endtask

  // Receiver stall bursts.
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // Result checker: sample mid-cycle, when valid and stall are settled.
  always @(negedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item_o);
      end else begin
        want = expected_q.pop_front();
        if (out_item_o.read_data !== want.read_data || out_item_o.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: read_data exp %h got %h, status exp %b got %b",
                     want.read_data, out_item_o.read_data, want.status, out_item_o.status);
        end
      end
    end
  end

  function automatic in_item_t make_item(cmd_e c, op_e o, int x, int y, int xl, int yl,
                                         int w, int h, int pat, bit inv);
    in_item_t it;
    it.cmd = c;  it.op = o;  it.x = 7'(x);  it.y = 6'(y);
    it.x_last = 7'(xl);  it.y_last = 6'(yl);  it.w = 8'(w);  it.h = 7'(h);
    it.pattern = 8'(pat);  it.invert = inv;
    return it;
  endfunction

  task automatic test_directed();
    send_item(make_item(CMD_READ,  OP_SET, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_POINT, OP_SET, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_POINT, OP_INV, 127, 63, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_HLINE, OP_SET, 3, 5, 120, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_HLINE, OP_SET, 9, 5, 4, 0, 0, 0, 0, 0));     // x_last below x
    send_item(make_item(CMD_VLINE, OP_CLR, 10, 2, 0, 60, 0, 0, 0, 0));
    send_item(make_item(CMD_VLINE, OP_SET, 10, 9, 0, 3, 0, 0, 0, 0));    // y_last below y
    send_item(make_item(CMD_RECT,  OP_INV, 5, 5, 0, 0, 12, 7, 0, 0));    // corners twice
    send_item(make_item(CMD_RECT,  OP_INV, 20, 20, 0, 0, 9, 1, 0, 0));   // one row
    send_item(make_item(CMD_RECT,  OP_INV, 20, 30, 0, 0, 1, 6, 0, 0));   // one column
    send_item(make_item(CMD_RECT,  OP_SET, 120, 60, 0, 0, 255, 127, 0, 0)); // off edge
    send_item(make_item(CMD_RECT,  OP_SET, 1, 1, 0, 0, 0, 5, 0, 0));     // empty
    send_item(make_item(CMD_FILL,  OP_SET, 3, 4, 0, 0, 3, 2, 0, 0));     // inside one element
    send_item(make_item(CMD_FILL,  OP_INV, 6, 8, 0, 0, 21, 3, 0, 0));
    send_item(make_item(CMD_FILL,  OP_CLR, 100, 50, 0, 0, 128, 64, 0, 0));
    send_item(make_item(CMD_FILL,  OP_SET, 0, 0, 0, 0, 4, 0, 0, 0));     // empty
    send_item(make_item(CMD_FILL,  OP_NOP, 126, 62, 0, 0, 5, 5, 0, 0));  // unused op, off edge
    send_item(make_item(CMD_SPR,   OP_CLR, 13, 7, 0, 0, 8, 0, 8'hA5, 0));
    send_item(make_item(CMD_SPR,   OP_SET, 124, 7, 0, 0, 200, 0, 8'h3C, 1)); // wide, off edge
    send_item(make_item(CMD_SPR,   OP_SET, 40, 7, 0, 0, 0, 0, 8'hFF, 0));
    send_item(make_item(CMD_READ,  OP_SET, 13, 7, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_READ,  OP_SET, 127, 63, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_ALL,   OP_INV, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_ALL,   OP_NOP, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_READ,  OP_SET, 8, 5, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random(int n);
    in_item_t it;
    int sel;
    for (int k = 0; k < n; k++) begin
      // every field gets random bits, op 3 included
      it = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
      sel = $urandom_range(0, 99);
      if (sel < 2)       it.cmd = CMD_ALL;
      else if (sel < 30) it.cmd = CMD_READ;
      else begin
        it.cmd = 3'($urandom_range(0, 6));
        if (it.cmd == CMD_ALL) it.cmd = CMD_POINT;
      end
      // Keep rectangles mostly small; a few keep their full random size, past the edge.
      if ((it.cmd == CMD_FILL || it.cmd == CMD_RECT) && $urandom_range(0, 19) != 0) begin
        it.w = 8'($urandom_range(0, 24));
        it.h = 7'($urandom_range(0, 10));
      end
      if (it.cmd == CMD_SPR && $urandom_range(0, 3) != 0) it.w = 8'($urandom_range(0, 9));
      send_item(it);
    end
  endtask

  task automatic test_drain();
    int guard;
    guard = 0;
    while (expected_q.size() != 0 && guard < 100_000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (100) @(posedge clk_i);
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    mismatches = 0;
    results_seen = 0;
    calm = 1'b0;
    foreach (shadow_fb[i]) shadow_fb[i] = '0;
    foreach (cmd_count[i]) cmd_count[i] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(850);
    calm = 1'b1;
    test_random(150);
    in_valid_i <= 1'b0;
    test_drain();
    $display("covered %0d results: point %0d hline %0d vline %0d rect %0d fill %0d",
             results_seen, cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3], cmd_count[4]);
    $display("fill-all %0d sprite %0d read %0d; %0d mismatches",
             cmd_count[5], cmd_count[6], cmd_count[7], mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[mono_bitmap_raster_engine.f]
hw/rtl/mbre_pkg.sv
hw/rtl/mbre_front.sv
hw/rtl/mbre_queue.sv
hw/rtl/mbre_back.sv
hw/rtl/mono_bitmap_raster_engine.sv
verif/mono_bitmap_raster_engine_tb.sv
